// ===== hdl/wsp_pkg.sv =====
// Shared types, constants and lookup functions for the wavetable synth with pitch modulation.
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

   // Table geometry default
   localparam int TABLE_DEPTH_DEF = 64;

   // Shared multiplier widths
   localparam int MUL_A_W = 13;
   localparam int MUL_B_W = 12;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Configuration register indexes
   localparam logic [2:0] CSR_MAIN_PITCH     = 3'd0;
   localparam logic [2:0] CSR_MOD_PITCH      = 3'd1;
   localparam logic [2:0] CSR_MASTER_ENV     = 3'd2;
   localparam logic [2:0] CSR_VOL_ENV_CTRL   = 3'd3;
   localparam logic [2:0] CSR_SWEEP_ENV_CTRL = 3'd4;
   localparam logic [2:0] CSR_CONTROL_FLAGS  = 3'd5;
   localparam logic [2:0] CSR_MASTER_VOL_SEL = 3'd6;

   // Control flag bit positions
   localparam int FLAG_HALT      = 0;
   localparam int FLAG_ENV_OFF   = 1;
   localparam int FLAG_MOD_OFF   = 2;
   localparam int FLAG_WAVE_WREN = 3;

   // Command codes carried by an input beat
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_WAVE_WR   = 3'd1,
      CMD_MOD_WR    = 3'd2,
      CMD_SET_BIAS  = 3'd3,
      CMD_SET_VOL   = 3'd4,
      CMD_SET_SWEEP = 3'd5
   } cmd_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD,
      ST_VOL_MUL,
      ST_VOL_UPD,
      ST_SWP_MUL,
      ST_SWP_UPD,
      ST_MOD,
      ST_OFS_MUL,
      ST_OFS_RND,
      ST_OFS_SCL,
      ST_OFS_UPD,
      ST_WAVE,
      ST_LVL_GAIN,
      ST_LVL_MUL,
      ST_LVL_UPD,
      ST_DONE
   } state_type;

   // Operand selection for the shared multiplier
   typedef enum logic [2:0] {
      MS_NONE,
      MS_VOL_RATE,
      MS_SWP_RATE,
      MS_BIAS_GAIN,
      MS_PITCH_T,
      MS_GAIN_MULT,
      MS_SAMPLE_LEVEL
   } mul_sel_type;

   // Per-state control decoded by the sequencer
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        req_ready;
      logic        out_load;
   } ctrl_type;

   // Envelope count and gain pair
   typedef struct packed {
      logic [16:0] count;
      logic [5:0]  gain;
   } env_type;

   // Bias step for a modulation code; code four adds nothing
   function automatic logic signed [6:0] step_adj(input logic [2:0] code);
      logic signed [6:0] r;
      case (code)
         3'd0:    r = 7'sd0;
         3'd1:    r = 7'sd1;
         3'd2:    r = 7'sd2;
         3'd3:    r = 7'sd4;
         3'd4:    r = 7'sd0;
         3'd5:    r = -7'sd4;
         3'd6:    r = -7'sd2;
         default: r = -7'sd1;
      endcase
      return r;
   endfunction

   // Master level multiplier
   function automatic logic [5:0] level_mult(input logic [1:0] sel);
      logic [5:0] r;
      case (sel)
         2'd0:    r = 6'd36;
         2'd1:    r = 6'd24;
         2'd2:    r = 6'd17;
         default: r = 6'd14;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/wavetable_synth_pitch_mod.sv =====
// Top level of the wavetable synth with pitch modulation and envelopes.
//
// Usage: each input beat on req_* carries a command. A tick advances the
// envelopes, the modulation accumulator and the wave accumulator; the other
// commands write a table entry, the bias or a gain. Every beat yields one
// result beat on rsp_* with the held output level and a wave-step flag.
// Configuration registers are written through csr_we/csr_index/csr_wdata;
// writes take effect at once. The user must write them only while no beat
// is in flight; the block does not enforce this. A tick steps the sequencer
// through the envelope states, the modulation state, the offset states when
// the modulation phase wraps, the wave state, the level states when the
// wave steps, then ST_DONE. One registered multiplier serves the envelope
// reload, the bias scaling, the pitch scaling and the sample level (up to
// six products per tick). Other commands pass through ST_CMD to ST_DONE.
// req_ready is high only while the sequencer is idle. A stalled result
// waits in the output register while the next beat is accepted and worked;
// that beat then holds in its last state until the register frees.
// Reset: synchronous, active high; clears the configuration, sequencer,
// voice and rsp_valid registers; table entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_synth_pitch_mod
   import wsp_pkg::*;
#(
   parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int IdxW        = $clog2(TABLE_DEPTH)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   // configuration port
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [11:0]     csr_wdata,
   // input channel
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [2:0]      req_command,
   input  wire logic [IdxW-1:0] req_entry_index,
   input  wire logic [6:0]      req_entry_value,
   // result channel
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [13:0]          rsp_sample_out,
   output logic                 rsp_wave_stepped
);

   // Configuration registers
   logic [11:0] main_pitch_ff;
   logic [11:0] mod_pitch_ff;
   logic [7:0]  master_env_ff;
   logic [7:0]  vol_ctrl_ff;
   logic [7:0]  swp_ctrl_ff;
   logic [3:0]  flags_ff;
   logic [1:0]  vol_sel_ff;

   // Tables
   logic [5:0] wave_mem [TABLE_DEPTH];
   logic [2:0] mod_mem  [TABLE_DEPTH];
   logic [5:0] wave_rd_ff;
   logic [2:0] mod_rd_ff;

   // Captured beat
   logic [2:0]      cmd_ff;
   logic [IdxW-1:0] idx_ff;
   logic [6:0]      val_ff;

   // Voice state
   logic [5:0]        vol_gain_ff,  vol_gain_in;
   logic [5:0]        swp_gain_ff,  swp_gain_in;
   logic [16:0]       vol_cnt_ff,   vol_cnt_in;
   logic [16:0]       swp_cnt_ff,   swp_cnt_in;
   logic [15:0]       mod_phase_ff, mod_phase_in;
   logic [IdxW-1:0]   mod_index_ff, mod_index_in;
   logic signed [6:0] bias_ff,      bias_in;
   logic signed [8:0] t_ff,         t_in;
   logic signed [14:0] pofs_ff,     pofs_in;
   logic [15:0]       wave_phase_ff, wave_phase_in;
   logic [IdxW-1:0]   wave_index_ff, wave_index_in;
   logic [13:0]       level_ff,     level_in;
   logic              stepped_ff,   stepped_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] rsp_sample_ff;
   logic        rsp_stepped_ff;

   // Sequencer
   state_type state_ff, state_in;
   ctrl_type  ctrl;

   // Shared multiplier
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [MUL_P_W-1:0] prod;

   // Datapath terms
   logic               req_fire;
   logic               out_free;
   logic               env_en;
   env_type            vol_nx, swp_nx;
   logic               mod_run;
   logic signed [16:0] mod_diff;
   logic signed [9:0]  ofs_sh, ofs_adj, ofs_wrap;
   logic signed [14:0] ofs_round;
   logic               fm_on;
   logic signed [16:0] freq;
   logic               wave_run;
   logic signed [17:0] wave_diff;
   logic [5:0]         vol_lim;

   // Step one envelope: count down, reload and move the gain at zero
   function automatic env_type env_advance(input logic [16:0] count,
                                           input logic [5:0]  gain,
                                           input logic [7:0]  ctrl_reg,
                                           input logic [13:0] rate);
      env_type     r;
      logic [16:0] dec;
      r.count = count;
      r.gain  = gain;
      dec     = count - 17'd1;
      if (!ctrl_reg[7]) begin
         r.count = dec;
         if (dec == 17'd0) begin
            r.count = {rate, 3'b000};
            if (ctrl_reg[6]) begin
               if (gain < 6'd32) r.gain = gain + 6'd1;
            end else if (gain != 6'd0) begin
               r.gain = gain - 6'd1;
            end
         end
      end
      return r;
   endfunction

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         main_pitch_ff <= '0;
         mod_pitch_ff  <= '0;
         master_env_ff <= '0;
         vol_ctrl_ff   <= '0;
         swp_ctrl_ff   <= '0;
         flags_ff      <= '0;
         vol_sel_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAIN_PITCH:     main_pitch_ff <= csr_wdata;
            CSR_MOD_PITCH:      mod_pitch_ff  <= csr_wdata;
            CSR_MASTER_ENV:     master_env_ff <= csr_wdata[7:0];
            CSR_VOL_ENV_CTRL:   vol_ctrl_ff   <= csr_wdata[7:0];
            CSR_SWEEP_ENV_CTRL: swp_ctrl_ff   <= csr_wdata[7:0];
            CSR_CONTROL_FLAGS:  flags_ff      <= csr_wdata[3:0];
            CSR_MASTER_VOL_SEL: vol_sel_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Table writes in ST_CMD and registered reads at beat acceptance
   always_ff @(posedge clock) begin
      if (state_ff == ST_CMD && cmd_ff == CMD_WAVE_WR && flags_ff[FLAG_WAVE_WREN]) begin
         wave_mem[idx_ff] <= val_ff[5:0];
      end
      if (state_ff == ST_CMD && cmd_ff == CMD_MOD_WR) begin
         mod_mem[idx_ff] <= val_ff[2:0];
      end
      if (req_fire) begin
         wave_rd_ff <= wave_mem[wave_index_ff];
         mod_rd_ff  <= mod_mem[mod_index_ff];
      end
   end

   // Capture the beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_command;
         idx_ff <= req_entry_index;
         val_ff <= req_entry_value;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = (req_command == CMD_TICK) ? ST_VOL_MUL : ST_CMD;
         end
         ST_CMD:      state_in = ST_DONE;
         ST_VOL_MUL:  state_in = ST_VOL_UPD;
         ST_VOL_UPD:  state_in = ST_SWP_MUL;
         ST_SWP_MUL:  state_in = ST_SWP_UPD;
         ST_SWP_UPD:  state_in = ST_MOD;
         ST_MOD:      state_in = (mod_run && mod_diff[16]) ? ST_OFS_MUL : ST_WAVE;
         ST_OFS_MUL:  state_in = ST_OFS_RND;
         ST_OFS_RND:  state_in = ST_OFS_SCL;
         ST_OFS_SCL:  state_in = ST_OFS_UPD;
         ST_OFS_UPD:  state_in = ST_WAVE;
         ST_WAVE: begin
            if (!flags_ff[FLAG_HALT] && wave_run && wave_diff[17]) state_in = ST_LVL_GAIN;
            else state_in = ST_DONE;
         end
         ST_LVL_GAIN: state_in = ST_LVL_MUL;
         ST_LVL_MUL:  state_in = ST_LVL_UPD;
         ST_LVL_UPD:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctrl = '{mul_sel: MS_NONE, req_ready: 1'b0, out_load: 1'b0};
      unique case (state_ff)
         ST_IDLE:     ctrl.req_ready = 1'b1;
         ST_VOL_MUL:  ctrl.mul_sel   = MS_VOL_RATE;
         ST_SWP_MUL:  ctrl.mul_sel   = MS_SWP_RATE;
         ST_OFS_MUL:  ctrl.mul_sel   = MS_BIAS_GAIN;
         ST_OFS_SCL:  ctrl.mul_sel   = MS_PITCH_T;
         ST_LVL_GAIN: ctrl.mul_sel   = MS_GAIN_MULT;
         ST_LVL_MUL:  ctrl.mul_sel   = MS_SAMPLE_LEVEL;
         ST_DONE:     ctrl.out_load  = out_free;
         default: ;
      endcase
   end

   assign req_ready = ctrl.req_ready;

   // Select multiplier operands
   assign vol_lim = (vol_gain_ff >= 6'd32) ? 6'd32 : vol_gain_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctrl.mul_sel)
         MS_VOL_RATE: begin
            op_a = {5'b0, master_env_ff};
            op_b = {5'b0, 7'({1'b0, vol_ctrl_ff[5:0]} + 7'd1)};
         end
         MS_SWP_RATE: begin
            op_a = {5'b0, master_env_ff};
            op_b = {5'b0, 7'({1'b0, swp_ctrl_ff[5:0]} + 7'd1)};
         end
         MS_BIAS_GAIN: begin
            op_a = {{6{bias_ff[6]}}, bias_ff};
            op_b = {6'b0, swp_gain_ff};
         end
         MS_PITCH_T: begin
            op_a = {1'b0, main_pitch_ff};
            op_b = {{3{t_ff[8]}}, t_ff};
         end
         MS_GAIN_MULT: begin
            op_a = {7'b0, vol_lim};
            op_b = {6'b0, level_mult(vol_sel_ff)};
         end
         MS_SAMPLE_LEVEL: begin
            op_a = {7'b0, wave_rd_ff};
            op_b = prod[11:0];
         end
         default: ;
      endcase
   end

   wsp_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (prod)
   );

   // Envelope, modulation and wave terms
   assign env_en   = !flags_ff[FLAG_ENV_OFF] && !flags_ff[FLAG_HALT] && (master_env_ff != 8'd0);
   assign vol_nx   = env_advance(vol_cnt_ff, vol_gain_ff, vol_ctrl_ff, prod[13:0]);
   assign swp_nx   = env_advance(swp_cnt_ff, swp_gain_ff, swp_ctrl_ff, prod[13:0]);
   assign mod_run  = !flags_ff[FLAG_MOD_OFF] && (mod_pitch_ff != 12'd0);
   assign mod_diff = $signed({1'b0, mod_phase_ff}) - $signed({5'b0, mod_pitch_ff});

   // Round bias times gain by sixteen, then wrap into the offset window
   assign ofs_sh = prod[13:4];
   always_comb begin
      ofs_adj = ofs_sh;
      if ((prod[3:0] != 4'd0) && !ofs_sh[7]) begin
         ofs_adj = bias_ff[6] ? (ofs_sh - 10'sd1) : (ofs_sh + 10'sd2);
      end
      ofs_wrap = ofs_adj;
      if (ofs_adj >= 10'sd192)     ofs_wrap = ofs_adj - 10'sd256;
      else if (ofs_adj < -10'sd64) ofs_wrap = ofs_adj + 10'sd256;
   end
   assign t_in = ofs_wrap[8:0];

   // Round pitch times offset by sixty-four
   assign ofs_round = prod[20:6] + {14'b0, prod[5]};

   assign fm_on     = mod_run && (main_pitch_ff != 12'd0);
   assign freq      = $signed({5'b0, main_pitch_ff}) +
                      (fm_on ? {{2{pofs_ff[14]}}, pofs_ff} : 17'sd0);
   assign wave_run  = !freq[16] && (freq != 17'sd0) && !flags_ff[FLAG_WAVE_WREN];
   assign wave_diff = $signed({2'b0, wave_phase_ff}) - {freq[16], freq};

   // Voice state next values
   always_comb begin
      vol_gain_in   = vol_gain_ff;
      swp_gain_in   = swp_gain_ff;
      vol_cnt_in    = vol_cnt_ff;
      swp_cnt_in    = swp_cnt_ff;
      mod_phase_in  = mod_phase_ff;
      mod_index_in  = mod_index_ff;
      bias_in       = bias_ff;
      pofs_in       = pofs_ff;
      wave_phase_in = wave_phase_ff;
      wave_index_in = wave_index_ff;
      level_in      = level_ff;
      stepped_in    = stepped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) stepped_in = 1'b0;
         end
         ST_CMD: begin
            case (cmd_ff)
               CMD_SET_BIAS:  bias_in     = val_ff;
               CMD_SET_VOL:   vol_gain_in = val_ff[5:0];
               CMD_SET_SWEEP: swp_gain_in = val_ff[5:0];
               default: ;
            endcase
         end
         ST_VOL_UPD: begin
            if (env_en) begin
               vol_cnt_in  = vol_nx.count;
               vol_gain_in = vol_nx.gain;
            end
         end
         ST_SWP_UPD: begin
            if (env_en) begin
               swp_cnt_in  = swp_nx.count;
               swp_gain_in = swp_nx.gain;
            end
         end
         ST_MOD: begin
            // advance phase; on wrap step the table index and the bias
            if (mod_run) begin
               mod_phase_in = mod_diff[15:0];
               if (mod_diff[16]) begin
                  mod_index_in = mod_index_ff + IdxW'(1);
                  bias_in      = bias_ff + step_adj(mod_rd_ff);
               end
            end
         end
         ST_OFS_UPD:  pofs_in = ofs_round;
         ST_WAVE: begin
            if (flags_ff[FLAG_HALT]) begin
               level_in      = '0;
               wave_index_in = '0;
            end else if (wave_run) begin
               wave_phase_in = wave_diff[15:0];
               if (wave_diff[17]) begin
                  wave_index_in = wave_index_ff + IdxW'(1);
                  stepped_in    = 1'b1;
               end
            end
         end
         ST_LVL_UPD:  level_in = prod[16:3];
         default: ;
      endcase
   end

   // Sequencer and voice state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vol_gain_ff   <= '0;
         swp_gain_ff   <= '0;
         vol_cnt_ff    <= '0;
         swp_cnt_ff    <= '0;
         mod_phase_ff  <= 16'hFFFF;
         mod_index_ff  <= '0;
         bias_ff       <= '0;
         pofs_ff       <= '0;
         wave_phase_ff <= 16'hFFFF;
         wave_index_ff <= '0;
         level_ff      <= '0;
         stepped_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vol_gain_ff   <= vol_gain_in;
         swp_gain_ff   <= swp_gain_in;
         vol_cnt_ff    <= vol_cnt_in;
         swp_cnt_ff    <= swp_cnt_in;
         mod_phase_ff  <= mod_phase_in;
         mod_index_ff  <= mod_index_in;
         bias_ff       <= bias_in;
         pofs_ff       <= pofs_in;
         wave_phase_ff <= wave_phase_in;
         wave_index_ff <= wave_index_in;
         level_ff      <= level_in;
         stepped_ff    <= stepped_in;
      end
   end

   // Hold the offset operand between its rounding and scaling steps
   always_ff @(posedge clock) begin
      if (state_ff == ST_OFS_RND) t_ff <= t_in;
   end

   // Result register: load a beat when free, drop it when taken
   assign rsp_valid_in = ctrl.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_sample_ff  <= level_ff;
         rsp_stepped_ff <= stepped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_wave_stepped = rsp_stepped_ff;

endmodule

`default_nettype wire

// ===== hdl/wsp_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module wsp_mul
   import wsp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic signed [MUL_A_W-1:0]  op_a,
   input  wire logic signed [MUL_B_W-1:0]  op_b,
   output logic signed [MUL_P_W-1:0]       product
);

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   // Form the full-width product
   assign product_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   // Register the product every cycle
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== hdl/wsp_check.sv =====
// Port-level checker for the wavetable synth, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wsp_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [13:0] rsp_sample_out,
   input wire logic        rsp_wave_stepped
);

   // The block is ready for a beat right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low after reset");

   // The sequencer is busy in the cycle after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   // Output level never exceeds full-scale sample times full level
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_out <= 14'd9072))
      else $error("rsp_sample_out above full scale");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_sample_out) && $stable(rsp_wave_stepped)))
      else $error("rsp payload changed while stalled");

endmodule

bind wavetable_synth_pitch_mod wsp_check u_wsp_check (.*);

`default_nettype wire
